// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Each macro clocks on the rising edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hdl/wpde_pkg.sv -----
// ----------------------------------------------------------------------------
// wpde_pkg
// Shared widths, codes, controller/datapath interface types and the quotient
// saturation function of the position derivative estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package wpde_pkg;

	localparam int DATA_W  = 32;  // velocity, acceleration, jerk, raw sample
	localparam int POS_W   = 48;  // unwrapped position
	localparam int NUM_W   = 49;  // position delta, widest dividend
	localparam int SHORT_W = 33;  // difference of two 32-bit derivatives
	localparam int LIMIT_W = 31;  // wrap period

	// configuration register indexes
	typedef enum logic {
		REG_MODULAR_ENABLE = 1'b0,
		REG_MOD_LIMIT      = 1'b1
	} cfg_reg_t;

	// which quantity the shared divider works on
	typedef enum logic [1:0] {
		SEL_MOD = 2'd0,
		SEL_VEL = 2'd1,
		SEL_ACC = 2'd2,
		SEL_JRK = 2'd3
	} div_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic     capture;    // latch a new input word
		logic     delta;      // form position delta and interval
		logic     div_start;  // load divider operands for sel
		div_sel_t sel;
		logic     take;       // store divider result for sel
		logic     commit;     // update state and load output word
	} wpde_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       div_done;
		logic       first;    // no sample seen yet
		logic       modular;  // wrap enabled with a nonzero period
		logic [1:0] stage;
	} wpde_sts_t;

	localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(32'h7FFF_FFFF);
	localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(33'h0_8000_0000);

	// Signed quotient from magnitude and sign, saturated to 32 bits.
	// A zero numerator gives zero even for a zero divisor.
	function automatic logic [DATA_W-1:0] sat_quot(
		input logic             neg,
		input logic             zero,
		input logic [NUM_W-1:0] q
	);
		logic [DATA_W-1:0] r;
		if (zero) begin
			r = '0;
		end else if (neg) begin
			r = (q > NEG_LIM) ? 32'h8000_0000 : (~q[DATA_W-1:0] + 32'd1);
		end else begin
			r = (q > POS_LIM) ? 32'h7FFF_FFFF : q[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/wpde_div.sv -----
// ----------------------------------------------------------------------------
// wpde_div
// Unsigned restoring divider, one quotient bit per cycle. A short operation
// takes its dividend left aligned and runs SHORT_W steps instead of NUM_W.
// ----------------------------------------------------------------------------
`default_nettype none

module wpde_div #(
	parameter int NUM_W   = 49,
	parameter int DEN_W   = 32,
	parameter int SHORT_W = 33
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             long_op,
	input  wire logic [NUM_W-1:0] dividend,
	input  wire logic [DEN_W-1:0] divisor,
	output logic      [NUM_W-1:0] quot,
	output logic      [DEN_W-1:0] rem,
	output logic                  done
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;
	logic             ge;

	// one compare-subtract step
	assign trial = {rem_q, quot_q[NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = ~diff[DEN_W+1];

	// control: step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= long_op ? CNT_W'(NUM_W) : CNT_W'(SHORT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[NUM_W-2:0], ge};
			rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign quot = quot_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ----- hdl/wpde_ctrl.sv -----
// ----------------------------------------------------------------------------
// wpde_ctrl
// Sequencer: accepts a word, orders the wrap reduction and the derivative
// divisions on the shared divider, and owns the output word's valid.
// ----------------------------------------------------------------------------
`default_nettype none

module wpde_ctrl
	import wpde_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	input  wire wpde_sts_t sts,
	output wpde_cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DELTA,
		S_MOD_GO,
		S_MOD_WAIT,
		S_VEL_GO,
		S_VEL_WAIT,
		S_ACC_GO,
		S_ACC_WAIT,
		S_JRK_GO,
		S_JRK_WAIT,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = ~out_valid_q | ~out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.sel       = SEL_MOD;
		cmd.capture   = (state_q == S_IDLE) & in_valid;
		cmd.delta     = (state_q == S_DELTA);
		cmd.commit    = (state_q == S_DONE) & out_free;
		unique case (state_q)
			S_MOD_GO, S_MOD_WAIT: cmd.sel = SEL_MOD;
			S_VEL_GO, S_VEL_WAIT: cmd.sel = SEL_VEL;
			S_ACC_GO, S_ACC_WAIT: cmd.sel = SEL_ACC;
			S_JRK_GO, S_JRK_WAIT: cmd.sel = SEL_JRK;
			default:              cmd.sel = SEL_MOD;
		endcase
		cmd.div_start = (state_q == S_MOD_GO) | (state_q == S_VEL_GO) |
		                (state_q == S_ACC_GO) | (state_q == S_JRK_GO);
		cmd.take      = sts.div_done &
		                ((state_q == S_MOD_WAIT) | (state_q == S_VEL_WAIT) |
		                 (state_q == S_ACC_WAIT) | (state_q == S_JRK_WAIT));
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// load a finished word, or drop valid once the word is taken
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DELTA;
				end
				S_DELTA: begin
					if (sts.first)        state_q <= S_DONE;
					else if (sts.modular) state_q <= S_MOD_GO;
					else                  state_q <= S_VEL_GO;
				end
				S_MOD_GO: state_q <= S_MOD_WAIT;
				S_MOD_WAIT: begin
					if (sts.div_done) state_q <= S_VEL_GO;
				end
				S_VEL_GO: state_q <= S_VEL_WAIT;
				S_VEL_WAIT: begin
					if (sts.div_done) state_q <= (sts.stage >= 2'd2) ? S_ACC_GO : S_DONE;
				end
				S_ACC_GO: state_q <= S_ACC_WAIT;
				S_ACC_WAIT: begin
					if (sts.div_done) state_q <= (sts.stage == 2'd3) ? S_JRK_GO : S_DONE;
				end
				S_JRK_GO: state_q <= S_JRK_WAIT;
				S_JRK_WAIT: begin
					if (sts.div_done) state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/wpde_dp.sv -----
// ----------------------------------------------------------------------------
// wpde_dp
// Datapath: configuration registers, estimator state, position delta and
// wrap folding, operand selection for the shared divider, output word.
// ----------------------------------------------------------------------------
`default_nettype none

module wpde_dp
	import wpde_pkg::*;
#(
	parameter int TIME_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_wr_en,
	input  wire logic                    cfg_index,
	input  wire logic [LIMIT_W-1:0]      cfg_data,
	input  wire logic [TIME_WIDTH-1:0]   sample_time,
	input  wire logic signed [DATA_W-1:0] sample_x,
	input  wire wpde_cmd_t               cmd,
	output wpde_sts_t                    sts,
	output logic signed [POS_W-1:0]      position,
	output logic signed [DATA_W-1:0]     velocity,
	output logic signed [DATA_W-1:0]     acceleration,
	output logic signed [DATA_W-1:0]     jerk,
	output logic [1:0]                   warmup_stage,
	output logic                         zero_interval
);

	localparam int DEN_W = (TIME_WIDTH > LIMIT_W) ? TIME_WIDTH : LIMIT_W;

	// configuration and estimator state
	logic                  mod_en_q;
	logic [LIMIT_W-1:0]    mod_limit_q;
	logic [1:0]            stage_q;
	logic [TIME_WIDTH-1:0] last_time_q;
	logic [POS_W-1:0]      upos_q;
	logic [DATA_W-1:0]     last_vel_q;
	logic [DATA_W-1:0]     last_acc_q;

	// working registers for the word in progress
	logic [TIME_WIDTH-1:0] t_q;
	logic [DATA_W-1:0]     x_q;
	logic [NUM_W-1:0]      d_q;
	logic [NUM_W-1:0]      dx_q;
	logic [DATA_W-1:0]     v_q;
	logic [DATA_W-1:0]     a_q;
	logic [DATA_W-1:0]     j_q;
	logic                  z_q;
	logic                  neg_q;
	logic                  zero_q;

	// output word
	logic [POS_W-1:0]      position_q;
	logic [DATA_W-1:0]     velocity_q;
	logic [DATA_W-1:0]     acceleration_q;
	logic [DATA_W-1:0]     jerk_q;
	logic [1:0]            warmup_q;
	logic                  zero_int_q;

	logic [NUM_W-1:0]      d_new;
	logic [TIME_WIDTH-1:0] dt;
	logic [SHORT_W-1:0]    acc_num;
	logic [SHORT_W-1:0]    jrk_num;
	logic [NUM_W-1:0]      num_s;
	logic [NUM_W-1:0]      mag;
	logic [NUM_W-1:0]      dividend;
	logic [DEN_W-1:0]      divisor;
	logic                  long_op;
	logic [NUM_W-1:0]      quot;
	logic [DEN_W-1:0]      rem;
	logic                  div_done;
	logic [DATA_W-1:0]     sat_q;
	logic [LIMIT_W-1:0]    r_lo;
	logic [LIMIT_W-1:0]    r_pos;
	logic [NUM_W-1:0]      fold_dx;
	logic [POS_W-1:0]      upos_new;

	// position delta, interval and derivative differences
	assign d_new   = {{(NUM_W-DATA_W){x_q[DATA_W-1]}}, x_q} - {upos_q[POS_W-1], upos_q};
	assign dt      = t_q - last_time_q;
	assign acc_num = {v_q[DATA_W-1], v_q} - {last_vel_q[DATA_W-1], last_vel_q};
	assign jrk_num = {a_q[DATA_W-1], a_q} - {last_acc_q[DATA_W-1], last_acc_q};

	// divider operand selection
	always_comb begin
		case (cmd.sel)
			SEL_MOD: num_s = d_q;
			SEL_VEL: num_s = dx_q;
			SEL_ACC: num_s = {{(NUM_W-SHORT_W){acc_num[SHORT_W-1]}}, acc_num};
			SEL_JRK: num_s = {{(NUM_W-SHORT_W){jrk_num[SHORT_W-1]}}, jrk_num};
			default: num_s = dx_q;
		endcase
		mag      = num_s[NUM_W-1] ? (~num_s + NUM_W'(1)) : num_s;
		long_op  = (cmd.sel == SEL_MOD) | (cmd.sel == SEL_VEL);
		dividend = long_op ? mag : {mag[SHORT_W-1:0], {(NUM_W-SHORT_W){1'b0}}};
		divisor  = (cmd.sel == SEL_MOD) ? DEN_W'(mod_limit_q) : DEN_W'(dt);
	end

	wpde_div #(
		.NUM_W  (NUM_W),
		.DEN_W  (DEN_W),
		.SHORT_W(SHORT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.long_op (long_op),
		.dividend(dividend),
		.divisor (divisor),
		.quot    (quot),
		.rem     (rem),
		.done    (div_done)
	);

	assign sat_q = sat_quot(neg_q, zero_q, quot);

	// floored remainder, then folded to the signed short way
	assign r_lo  = rem[LIMIT_W-1:0];
	assign r_pos = (neg_q && (r_lo != '0)) ? (mod_limit_q - r_lo) : r_lo;
	assign fold_dx = ({r_pos, 1'b0} > {1'b0, mod_limit_q}) ?
	                 {{(NUM_W-LIMIT_W){1'b1}}, r_pos - mod_limit_q} :
	                 {{(NUM_W-LIMIT_W){1'b0}}, r_pos};

	assign upos_new = (stage_q == 2'd0) ? {{(POS_W-DATA_W){x_q[DATA_W-1]}}, x_q} :
	                                      (upos_q + dx_q[POS_W-1:0]);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_en_q    <= 1'b0;
			mod_limit_q <= LIMIT_W'(1) << FRAC_BITS;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODULAR_ENABLE: mod_en_q    <= cfg_data[0];
				REG_MOD_LIMIT:      mod_limit_q <= cfg_data;
				default:            mod_en_q    <= mod_en_q;
			endcase
		end
	end

	// estimator state, updated once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= '0;
			last_time_q <= '0;
			upos_q      <= '0;
			last_vel_q  <= '0;
			last_acc_q  <= '0;
		end else if (cmd.commit) begin
			stage_q     <= (stage_q == 2'd3) ? stage_q : (stage_q + 2'd1);
			last_time_q <= t_q;
			upos_q      <= upos_new;
			last_vel_q  <= v_q;
			last_acc_q  <= a_q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			t_q <= sample_time;
			x_q <= sample_x;
			v_q <= '0;
			a_q <= '0;
			j_q <= '0;
		end
		if (cmd.delta) begin
			d_q  <= d_new;
			dx_q <= d_new;
			z_q  <= (stage_q != 2'd0) & (dt == '0);
		end
		if (cmd.div_start) begin
			neg_q  <= num_s[NUM_W-1];
			zero_q <= (num_s == '0);
		end
		if (cmd.take) begin
			case (cmd.sel)
				SEL_MOD: dx_q <= fold_dx;
				SEL_VEL: v_q  <= sat_q;
				SEL_ACC: a_q  <= sat_q;
				SEL_JRK: j_q  <= sat_q;
				default: dx_q <= dx_q;
			endcase
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			position_q     <= upos_new;
			velocity_q     <= v_q;
			acceleration_q <= a_q;
			jerk_q         <= j_q;
			warmup_q       <= stage_q;
			zero_int_q     <= z_q;
		end
	end

	assign sts.div_done = div_done;
	assign sts.first    = (stage_q == 2'd0);
	assign sts.modular  = mod_en_q & (mod_limit_q != '0);
	assign sts.stage    = stage_q;

	assign position      = position_q;
	assign velocity      = velocity_q;
	assign acceleration  = acceleration_q;
	assign jerk          = jerk_q;
	assign warmup_stage  = warmup_q;
	assign zero_interval = zero_int_q;

endmodule

`default_nettype wire

// ----- hdl/wrapped_position_derivative_estimator.sv -----
// ----------------------------------------------------------------------------
// wrapped_position_derivative_estimator
// Unwrapped position and Euler velocity, acceleration and jerk from
// timestamped, possibly modular, position samples.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one word: sample_time, sample_x.
// Output channel (out_valid/out_stall) gives one word per input word.
// Configuration (cfg_wr_en, cfg_index, cfg_data) must be written by the
// user only while idle; the block does not enforce it. One word is
// processed at a time on a shared one-bit-per-cycle divider. The block
// forms the position delta, then, but for the first sample, runs the wrap
// reduction if wrapping, the velocity division, and the acceleration and
// jerk divisions once enough samples were seen, then the output load.
// The next input word can be taken in the cycle after the output load.
// A waiting output word does not block the next input word; the block only
// holds before its own output load while the previous word is stalled.
// Reset clears the estimator state (warm-up restarts), turns modular mode
// off, sets the period to one unit and drops out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module wrapped_position_derivative_estimator
	import wpde_pkg::*;
#(
	parameter int TIME_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic                     cfg_index,
	input  wire logic [LIMIT_W-1:0]       cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [TIME_WIDTH-1:0]    sample_time,
	input  wire logic signed [DATA_W-1:0] sample_x,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [POS_W-1:0]       position,
	output logic signed [DATA_W-1:0]      velocity,
	output logic signed [DATA_W-1:0]      acceleration,
	output logic signed [DATA_W-1:0]      jerk,
	output logic [1:0]                    warmup_stage,
	output logic                          zero_interval
);

	wpde_cmd_t cmd;
	wpde_sts_t sts;

	wpde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	wpde_dp #(
		.TIME_WIDTH(TIME_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_time  (sample_time),
		.sample_x     (sample_x),
		.cmd          (cmd),
		.sts          (sts),
		.position     (position),
		.velocity     (velocity),
		.acceleration (acceleration),
		.jerk         (jerk),
		.warmup_stage (warmup_stage),
		.zero_interval(zero_interval)
	);

endmodule

`default_nettype wire

// ----- hdl/wpde_checker.sv -----
// ----------------------------------------------------------------------------
// wpde_checker
// Port-level checks on the output channel of the estimator, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wpde_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [47:0] position,
	input wire logic [31:0] velocity,
	input wire logic [31:0] acceleration,
	input wire logic [31:0] jerk,
	input wire logic [1:0]  warmup_stage,
	input wire logic        zero_interval
);

	// a stalled word stays offered and its position unchanged
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid, "output word dropped while stalled")
	`ASSERT_CLK(a_pos_stable, clk, arst_n, out_valid && out_stall |=> $stable(position), "position changed while stalled")

	// first sample carries no derivatives and no zero-interval flag
	`ASSERT_NEVER(a_first_clean, clk, arst_n, out_valid && warmup_stage == 2'd0 && (velocity != 32'd0 || acceleration != 32'd0 || zero_interval), "derivative on first sample")

	// jerk only after three earlier samples
	`ASSERT_NEVER(a_jerk_warmup, clk, arst_n, out_valid && warmup_stage != 2'd3 && jerk != 32'd0, "jerk before warm-up done")

	// zero interval saturates velocity or leaves it zero
	`ASSERT_CLK(a_zero_sat, clk, arst_n, out_valid && zero_interval |-> (velocity == 32'h7FFF_FFFF || velocity == 32'h8000_0000 || velocity == 32'd0), "unsaturated velocity on zero interval")

endmodule

bind wrapped_position_derivative_estimator wpde_checker u_wpde_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wrapped position derivative estimator. Sample
// words go through a valid/stall driver with random gaps. A clocked monitor
// predicts each result word when its sample is accepted: the unwrapped
// position, and velocity, acceleration and jerk as saturating quotients over
// the tick interval. It then compares every returned word field by field.
// The run starts with directed samples: warm-up, zero intervals, the time
// wrap, the field extremes, half-period wrapping and the degenerate periods.
// Random phases follow, each with its own wrap setting.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
	import wpde_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SAT_MAX   = 64'sd2147483647;
	localparam longint SAT_MIN   = -64'sd2147483648;
	localparam int     DRAIN_CYC = 200;    // longer than the slowest word
	localparam int     LONG_HOLD = 600;    // receiver hold-off, in cycles

	typedef struct {
		logic [DATA_W-1:0] t;
		logic [DATA_W-1:0] x;
	} sample_word_t;

	typedef struct {
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] vel;
		logic [DATA_W-1:0] acc;
		logic [DATA_W-1:0] jrk;
		logic [1:0]        stage;
		logic              zero;
	} estimate_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = REG_MODULAR_ENABLE;
	logic [LIMIT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [DATA_W-1:0] sample_time = '0;
	logic signed [DATA_W-1:0] sample_x = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [POS_W-1:0] position;
	logic signed [DATA_W-1:0] velocity;
	logic signed [DATA_W-1:0] acceleration;
	logic signed [DATA_W-1:0] jerk;
	logic [1:0] warmup_stage;
	logic zero_interval;

	wrapped_position_derivative_estimator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_time  (sample_time),
		.sample_x     (sample_x),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.position     (position),
		.velocity     (velocity),
		.acceleration (acceleration),
		.jerk         (jerk),
		.warmup_stage (warmup_stage),
		.zero_interval(zero_interval)
	);

	// words waiting for the driver, and results still owed by the block
	sample_word_t sample_queue[$];
	estimate_t    expected_estimates[$];
	int           mismatches = 0;

	// estimator copy: wrap setting and tracking state
	logic               wrap_on = 1'b0;
	logic [LIMIT_W-1:0] wrap_period = LIMIT_W'(65536);
	logic [1:0]         est_stage = '0;
	logic [DATA_W-1:0]  est_last_time = '0;
	logic signed [POS_W-1:0] est_pos = '0;
	longint             est_last_vel = 0;
	longint             est_last_acc = 0;

	// handshake flags seen at the last rising edge
	logic in_fire = 1'b0;
	logic out_fire = 1'b0;
	logic out_seen = 1'b0;

	// random sample generator track
	logic [DATA_W-1:0] gen_time = '0;
	logic [DATA_W-1:0] gen_x = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// signed quotient toward zero, clamped to 32 bits; zero divisor saturates a nonzero numerator
	function automatic longint quotient_sat(longint num, longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		if (den == 0) begin
			if (num == 0)
				return 0;
			return (num < 0) ? SAT_MIN : SAT_MAX;
		end
		mag = (num < 0) ? longint'(-num) : longint'(num);
		q = mag / den;
		if (num < 0) begin
			if (q > 64'd2147483648)
				return SAT_MIN;
			return -longint'(q);
		end
		if (q > 64'd2147483647)
			return SAT_MAX;
		return longint'(q);
	endfunction

	// position step, taken the short way round when wrapping is on
	function automatic longint wrapped_delta(longint prev, longint x);
		longint d;
		longint m;
		d = x - prev;
		m = longint'(wrap_period);
		if (!wrap_on || m == 0)
			return d;
		d = d % m;
		if (d < 0)
			d += m;
		if (2 * d > m)
			return d - m;
		return d;
	endfunction

	// advance the estimator copy by one accepted word, queue the result
	task automatic predict_estimate(logic [DATA_W-1:0] t, logic signed [DATA_W-1:0] x);
		estimate_t e;
		logic [DATA_W-1:0] span;
		longint unsigned dt;
		longint prev;
		longint dx;
		longint v;
		longint a;
		longint j;
		v = 0;
		a = 0;
		j = 0;
		e.zero = 1'b0;
		e.stage = est_stage;
		if (est_stage == 2'd0) begin
			est_pos = POS_W'(longint'(x));
			est_last_vel = 0;
			est_last_acc = 0;
		end else begin
			span = t - est_last_time;
			dt = span;
			prev = est_pos;
			dx = wrapped_delta(prev, longint'(x));
			e.zero = (span == '0);
			v = quotient_sat(dx, dt);
			if (est_stage >= 2'd2)
				a = quotient_sat(v - est_last_vel, dt);
			if (est_stage == 2'd3)
				j = quotient_sat(a - est_last_acc, dt);
			est_pos = POS_W'(prev + dx);
			est_last_vel = v;
			est_last_acc = a;
		end
		est_last_time = t;
		if (est_stage != 2'd3)
			est_stage++;
		e.pos = est_pos;
		e.vel = DATA_W'(v);
		e.acc = DATA_W'(a);
		e.jrk = DATA_W'(j);
		expected_estimates.push_back(e);
	endtask

	task automatic compare_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_estimate();
		estimate_t e;
		if (expected_estimates.size() == 0) begin
			$display("%0t: unexpected result word, expected none, got position %h",
				$time, position);
			mismatches++;
		end else begin
			e = expected_estimates.pop_front();
			compare_field("position", e.pos, position);
			compare_field("velocity", e.vel, $unsigned(velocity));
			compare_field("acceleration", e.acc, $unsigned(acceleration));
			compare_field("jerk", e.jrk, $unsigned(jerk));
			compare_field("warmup_stage", e.stage, warmup_stage);
			compare_field("zero_interval", e.zero, zero_interval);
		end
	endtask

	// monitor: predict on input acceptance, check on output acceptance
	always @(posedge clk) begin
		in_fire <= in_valid && !in_stall;
		out_fire <= out_valid && !out_stall;
		out_seen <= out_valid;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_estimate(sample_time, sample_x);
			if (out_valid && !out_stall)
				check_estimate();
		end
	end

	// sample driver: random gap before each word, with gap-free stretches
	int           src_gap = 0;
	bit           src_steady = 1'b0;
	sample_word_t src_word;

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (src_gap != 0) begin
				src_gap--;
				in_valid <= 1'b0;
			end else if (sample_queue.size() != 0) begin
				src_word = sample_queue.pop_front();
				sample_time <= src_word.t;
				sample_x <= src_word.x;
				in_valid <= 1'b1;
				if ($urandom_range(0, 63) == 0)
					src_steady = !src_steady;
				src_gap = src_steady ? 0 : $urandom_range(0, 9);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver: random stall per word, two long hold-offs
	int sink_wait = 0;
	int hold_left = 0;
	int results_taken = 0;
	bit sink_steady = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire) begin
				results_taken++;
				if (results_taken == 150 || results_taken == 1000)
					hold_left = LONG_HOLD;
				if ($urandom_range(0, 63) == 0)
					sink_steady = !sink_steady;
				sink_wait = sink_steady ? 0 : $urandom_range(0, 9);
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (sink_wait != 0) begin
				if (out_seen)
					sink_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic queue_sample(logic [DATA_W-1:0] t, logic [DATA_W-1:0] x);
		sample_word_t w;
		w.t = t;
		w.x = x;
		sample_queue.push_back(w);
	endtask

	// sender pause: everything sent and every result word back
	task automatic wait_idle();
		while (sample_queue.size() != 0 || in_valid || expected_estimates.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [LIMIT_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_MODULAR_ENABLE: wrap_on = val[0];
			REG_MOD_LIMIT:      wrap_period = val;
			default:            ;
		endcase
	endtask

	task automatic set_mode(logic modular, logic [LIMIT_W-1:0] period);
		wait_idle();
		write_reg(REG_MODULAR_ENABLE, LIMIT_W'(modular));
		write_reg(REG_MOD_LIMIT, period);
	endtask

	// mostly smooth motion with short intervals, plus noise and extremes
	task automatic queue_random_samples(int count);
		int sel;
		logic [DATA_W-1:0] x;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 6)
				gen_time = gen_time;
			else if (sel < 11)
				gen_time = $urandom;
			else if (sel < 18)
				gen_time = gen_time + 1;
			else
				gen_time = gen_time + $urandom_range(1, 2000);
			sel = $urandom_range(0, 99);
			if (sel < 15) begin
				x = $urandom;
			end else if (sel < 20) begin
				case ($urandom_range(0, 3))
					0: x = 32'h7FFF_FFFF;
					1: x = 32'h8000_0000;
					2: x = '0;
					default: x = '1;
				endcase
			end else if (sel < 25) begin
				x = gen_x + $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
			end else begin
				x = gen_x + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			end
			gen_x = x;
			queue_sample(gen_time, x);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// plain differences: warm-up, zero intervals, time wrap, extremes
		set_mode(1'b0, LIMIT_W'(65536));
		queue_sample(32'd100, 32'h7FFF_FFFF);
		queue_sample(32'd100, 32'h8000_0000);
		queue_sample(32'd100, 32'h0000_0000);
		queue_sample(32'd103, 32'h0005_0000);
		queue_sample(32'd103, 32'h0005_0000);
		queue_sample(32'hFFFF_FFF0, 32'hFFFF_FFFF);
		queue_sample(32'h0000_0010, 32'h8000_0000);
		queue_sample(32'h0000_0010, 32'h7FFF_FFFF);
		queue_sample(32'h0000_0011, 32'h7FFF_FFFF);
		queue_sample(32'h0000_0010, 32'h0000_0000);

		// one revolution: realign, exact half period both ways, short way back
		set_mode(1'b1, LIMIT_W'(65536));
		queue_sample(32'h20, 32'h0000_0000);
		queue_sample(32'h21, 32'h0000_8000);
		queue_sample(32'h22, 32'h0000_0000);
		queue_sample(32'h23, 32'hFFFF_C000);
		queue_sample(32'h23, 32'h7FFF_FFFF);
		queue_sample(32'h30, 32'h8000_0000);

		// unit period: every step reduces to nothing
		set_mode(1'b1, LIMIT_W'(1));
		queue_sample(32'h31, 32'h1234_5678);
		queue_sample(32'h40, 32'hFFFF_FFFF);

		// zero period with wrapping on behaves as plain difference
		set_mode(1'b1, '0);
		queue_sample(32'h41, 32'h7FFF_FFFF);
		queue_sample(32'h42, 32'h8000_0000);

		gen_time = 32'h42;
		gen_x = 32'h8000_0000;
		set_mode(1'b1, LIMIT_W'(65536));
		queue_random_samples(290);
		set_mode(1'b1, LIMIT_W'(360 * 65536));
		queue_random_samples(290);
		set_mode(1'b0, LIMIT_W'($urandom_range(1, 32'h7FFF_FFFF)));
		queue_random_samples(290);
		set_mode(1'b1, LIMIT_W'(1));
		queue_random_samples(280);
		set_mode(1'b1, {LIMIT_W{1'b1}});
		queue_random_samples(290);
		set_mode(1'b1, '0);
		queue_random_samples(280);
		set_mode(1'b1, LIMIT_W'($urandom_range(1, 32'h7FFF_FFFF)));
		queue_random_samples(290);

		wait_idle();
		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatches == 0 && expected_estimates.size() == 0)
			$display("wrapped_position_derivative_estimator verification clean");
		else
			$display("wrapped_position_derivative_estimator verification failed");
		$finish;
	end

	// hang guard, several times the slowest legal run
	initial begin
		#25000000;
		$display("wrapped_position_derivative_estimator verification failed");
		$finish;
	end

endmodule

`default_nettype wire
